@@ sv/mbtcp_pkg.sv @@
// shared types and constants for the modbus tcp request framer
`default_nettype none
package mbtcp_pkg;

   localparam int REQ_DATA_W = 56;

   // function codes handled
   localparam logic [7:0] FC_READ_COILS      = 8'd1;
   localparam logic [7:0] FC_READ_DISCRETE   = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
   localparam logic [7:0] FC_READ_INPUT      = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
   localparam logic [7:0] FC_WRITE_REGISTER  = 8'd6;
   localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
   localparam logic [7:0] FC_WRITE_REGISTERS = 8'd16;

   // quantity limits
   localparam logic [10:0] READ_BITS_LIMIT  = 11'd2000;
   localparam logic [10:0] READ_WORDS_LIMIT = 11'd125;
   localparam logic [10:0] MAX_REGISTERS    = 11'd123;
   localparam logic [10:0] MAX_COILS        = 11'd1968;

   localparam logic [7:0]  UNIT_ID_RESET   = 8'd1;
   localparam logic [15:0] TID_RESET       = 16'd1;
   localparam logic [15:0] COIL_ON_WORD    = 16'hFF00;
   localparam logic [8:0]  SHORT_FRAME_LEN = 9'd6;
   localparam logic [8:0]  MULTI_LEN_BASE  = 9'd7;

   // byte positions inside a frame
   localparam logic [3:0] IDX_WORD_LO = 4'd11;
   localparam logic [3:0] IDX_COUNT   = 4'd12;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_REGS  = 2'd1,
      KIND_COILS = 2'd2
   } open_kind_type;

   typedef enum logic [1:0] {
      JOB_REJECT = 2'd0,
      JOB_FRAME  = 2'd1,
      JOB_REGS   = 2'd2,
      JOB_COIL   = 2'd3
   } job_kind_type;

   // one unit of work for the byte serializer
   typedef struct packed {
      job_kind_type kind;
      logic         multi;   // frame carries the byte count
      logic         done;    // data bytes close the frame
      logic [15:0]  tid;
      logic [8:0]   len;
      logic [7:0]   unit;
      logic [7:0]   fc;
      logic [15:0]  addr;
      logic [15:0]  word;    // quantity, single value, register word or coil byte
      logic [7:0]   count;
   } job_type;

   localparam int JOB_W = $bits(job_type);

endpackage
`default_nettype wire

@@ sv/mbtcp_front.sv @@
// request decoder: checks requests, keeps framing state, issues serializer jobs
`default_nettype none
module mbtcp_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [7:0]                      csr_wr_data,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [mbtcp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tuser,
   output logic                                 push,
   output mbtcp_pkg::job_type                   push_job,
   input  wire logic                            push_ready
);
   import mbtcp_pkg::*;

   logic [7:0]    unit_id_ff;
   logic [15:0]   tid_ff, tid_in;
   open_kind_type open_ff, open_in;
   logic [10:0]   left_ff, left_in;
   logic [7:0]    pack_ff, pack_in;
   logic [2:0]    pos_ff, pos_in;

   logic          accept;
   logic [7:0]    fc;
   logic [15:0]   addr;
   logic [10:0]   qty;
   logic [15:0]   val;
   logic          ok;
   logic          multi;
   logic [15:0]   word;
   logic [8:0]    len;
   logic [7:0]    count;
   logic [11:0]   coil_sum;
   logic [10:0]   left_dec;
   logic          done;
   logic [7:0]    pack_new;

   assign fc   = req_tdata[7:0];
   assign addr = req_tdata[23:8];
   assign qty  = req_tdata[34:24];
   assign val  = req_tdata[50:35];

   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;
   assign coil_sum   = {1'b0, qty} + 12'd7;
   assign left_dec   = left_ff - 11'd1;
   assign done       = (left_dec == 11'd0);
   assign pack_new   = pack_ff | (8'(val[0]) << pos_ff);

   // header decode
   always_comb begin
      ok    = 1'b0;
      multi = 1'b0;
      word  = {5'd0, qty};
      count = 8'd0;
      len   = SHORT_FRAME_LEN;
      unique case (fc) inside
         FC_READ_COILS, FC_READ_DISCRETE: begin
            ok = (qty != 11'd0) && (qty <= READ_BITS_LIMIT);
         end
         FC_READ_HOLDING, FC_READ_INPUT: begin
            ok = (qty != 11'd0) && (qty <= READ_WORDS_LIMIT);
         end
         FC_WRITE_COIL: begin
            ok   = 1'b1;
            word = val[0] ? COIL_ON_WORD : 16'd0;
         end
         FC_WRITE_REGISTER: begin
            ok   = 1'b1;
            word = val;
         end
         FC_WRITE_COILS: begin
            ok    = (qty != 11'd0) && (qty <= MAX_COILS);
            multi = 1'b1;
            count = coil_sum[10:3];
            len   = MULTI_LEN_BASE + {1'b0, count};
         end
         FC_WRITE_REGISTERS: begin
            ok    = (qty != 11'd0) && (qty <= MAX_REGISTERS);
            multi = 1'b1;
            count = {qty[6:0], 1'b0};
            len   = MULTI_LEN_BASE + {1'b0, count};
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      tid_in   = tid_ff;
      open_in  = open_ff;
      left_in  = left_ff;
      pack_in  = pack_ff;
      pos_in   = pos_ff;
      push     = 1'b0;
      push_job = '0;
      push_job.kind = JOB_REJECT;
      if (accept) begin
         if (!req_tuser) begin
            push = 1'b1;
            if (open_ff == KIND_NONE && ok) begin
               push_job.kind  = JOB_FRAME;
               push_job.multi = multi;
               push_job.tid   = tid_ff;
               push_job.len   = len;
               push_job.unit  = unit_id_ff;
               push_job.fc    = fc;
               push_job.addr  = addr;
               push_job.word  = word;
               push_job.count = count;
               tid_in = tid_ff + 16'd1;
               if (multi) begin
                  open_in = (fc == FC_WRITE_COILS) ? KIND_COILS : KIND_REGS;
                  left_in = qty;
                  pack_in = 8'd0;
                  pos_in  = 3'd0;
               end
            end
         end else if (open_ff == KIND_NONE || left_ff == 11'd0) begin
            push = 1'b1;
         end else begin
            left_in = left_dec;
            if (done) begin
               open_in = KIND_NONE;
            end
            push_job.done = done;
            if (open_ff == KIND_REGS) begin
               push          = 1'b1;
               push_job.kind = JOB_REGS;
               push_job.word = val;
            end else begin
               pos_in = pos_ff + 3'd1;
               if (pos_ff == 3'd7 || done) begin
                  // full coil byte or last coil
                  push          = 1'b1;
                  push_job.kind = JOB_COIL;
                  push_job.word = {8'd0, pack_new};
                  pack_in       = 8'd0;
                  pos_in        = 3'd0;
               end else begin
                  pack_in = pack_new;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_id_ff <= UNIT_ID_RESET;
         tid_ff     <= TID_RESET;
         open_ff    <= KIND_NONE;
         left_ff    <= 11'd0;
         pack_ff    <= 8'd0;
         pos_ff     <= 3'd0;
      end else begin
         if (csr_wr_en) begin
            unit_id_ff <= csr_wr_data;
         end
         tid_ff  <= tid_in;
         open_ff <= open_in;
         left_ff <= left_in;
         pack_ff <= pack_in;
         pos_ff  <= pos_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/mbtcp_queue.sv @@
// two-entry job queue between decoder and serializer
`default_nettype none
module mbtcp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mbtcp_pkg::job_type push_job,
   output logic                   push_ready,
   output logic                   pop_valid,
   output mbtcp_pkg::job_type     pop_job,
   input  wire logic              pop
);
   import mbtcp_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff, fill_in;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_job    = mem_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         fill_ff <= fill_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/mbtcp_back.sv @@
// byte serializer: walks a job out as frame bytes through an output register
`default_nettype none
module mbtcp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   input  wire mbtcp_pkg::job_type job,
   output logic                   job_pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser
);
   import mbtcp_pkg::*;

   job_type    cur_ff, cur_in;
   logic       busy_ff, busy_in;
   logic [3:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic       out_rej_ff;

   logic       load_out;
   logic       emit;
   logic       fin;
   logic       take;
   logic [7:0] byte_sel;
   logic       last_sel;
   logic       end_sel;

   // byte, last flag and end of job for the current position
   always_comb begin
      byte_sel = 8'd0;
      last_sel = 1'b0;
      end_sel  = 1'b0;
      unique case (cur_ff.kind)
         JOB_REJECT: begin
            last_sel = 1'b1;
            end_sel  = 1'b1;
         end
         JOB_FRAME: begin
            case (idx_ff)
               4'd0:    byte_sel = cur_ff.tid[15:8];
               4'd1:    byte_sel = cur_ff.tid[7:0];
               4'd4:    byte_sel = {7'd0, cur_ff.len[8]};
               4'd5:    byte_sel = cur_ff.len[7:0];
               4'd6:    byte_sel = cur_ff.unit;
               4'd7:    byte_sel = cur_ff.fc;
               4'd8:    byte_sel = cur_ff.addr[15:8];
               4'd9:    byte_sel = cur_ff.addr[7:0];
               4'd10:   byte_sel = cur_ff.word[15:8];
               4'd11:   byte_sel = cur_ff.word[7:0];
               4'd12:   byte_sel = cur_ff.count;
               default: byte_sel = 8'd0;
            endcase
            // multi-write heads continue with data bytes, so no last flag
            last_sel = (idx_ff == IDX_WORD_LO) && !cur_ff.multi;
            end_sel  = last_sel || (idx_ff == IDX_COUNT);
         end
         JOB_REGS: begin
            byte_sel = (idx_ff == 4'd0) ? cur_ff.word[15:8] : cur_ff.word[7:0];
            last_sel = (idx_ff != 4'd0) && cur_ff.done;
            end_sel  = (idx_ff != 4'd0);
         end
         JOB_COIL: begin
            byte_sel = cur_ff.word[7:0];
            last_sel = cur_ff.done;
            end_sel  = 1'b1;
         end
         default: begin
            end_sel = 1'b1;
         end
      endcase
   end

   assign load_out = !out_valid_ff || rsp_tready;
   assign emit     = busy_ff && load_out;
   assign fin      = emit && end_sel;
   assign take     = job_valid && (!busy_ff || fin);
   assign job_pop  = take;

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (take) begin
         cur_in  = job;
         busy_in = 1'b1;
         idx_in  = 4'd0;
      end else if (fin) begin
         busy_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 4'd1;
      end
      out_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      if (emit) begin
         out_byte_ff <= byte_sel;
         out_last_ff <= last_sel;
         out_rej_ff  <= (cur_ff.kind == JOB_REJECT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_rej_ff;

endmodule
`default_nettype wire

@@ sv/modbus_tcp_request_framer_top.sv @@
// top level of the modbus tcp request framer
// Turns request items into Modbus TCP request frames, one byte per output transfer, network
// order. A request is taken whenever the two-entry job queue has room, so the decoder runs
// ahead while the serializer is still sending. Output speed is set by the byte serializer,
// one byte per cycle with rsp_tready high: read and single-write headers are 12 bytes,
// multi-write heads 13, a register element 2, a coil element 1 per eight coils (none for a
// partial byte unless it holds the last coil), and a rejected request 1 byte. No clearing
// pass after reset.
`default_nettype none
module modbus_tcp_request_framer_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [7:0]                      csr_wr_data,  // unit_id
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // function_code[7:0], start_address[23:8], quantity[34:24], value[50:35], zero pad
   input  wire logic [mbtcp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tuser,    // command
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [7:0]                           rsp_tdata,    // frame_byte
   output logic                                 rsp_tlast,    // last_byte
   output logic                                 rsp_tuser     // rejected
);
   import mbtcp_pkg::*;

   logic    push;
   job_type push_job;
   logic    push_ready;
   logic    pop_valid;
   job_type pop_job;
   logic    pop;

   mbtcp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .push        (push),
      .push_job    (push_job),
      .push_ready  (push_ready)
   );

   mbtcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop        (pop)
   );

   mbtcp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job        (pop_job),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

@@ sv/mbtcp_checker.sv @@
// port-level checks for the modbus tcp request framer, bound to the top level
`default_nettype none
module mbtcp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast,
   input wire logic       rsp_tuser
);

   // a rejection always closes its result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("rejection without last flag");

   // a rejection carries a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("rejection with nonzero byte");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   // a stalled byte is held
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled output changed");

endmodule

bind modbus_tcp_request_framer_top mbtcp_checker u_mbtcp_checker (.*);
`default_nettype wire
